### sv/ordered_chained_hash_map_defines.svh
// Assertion macros for the ordered chained hash map.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ORDERED_CHAINED_HASH_MAP_DEFINES_SVH
`define ORDERED_CHAINED_HASH_MAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OCHM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OCHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ochm_pkg.sv
// Shared constants and types for the ordered chained hash map.
// Used by the controller, the datapath and the top level; no dependencies.
package ochm_pkg;

    localparam int CAPACITY = 256;

    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_GET      = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_READ_POS = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [4:0] cmd_t;

    localparam cmd_t C_NOP       = 5'd0;
    localparam cmd_t C_SWEEP     = 5'd1;
    localparam cmd_t C_LATCH     = 5'd2;
    localparam cmd_t C_HEAD_RD   = 5'd3;
    localparam cmd_t C_CUR_LD    = 5'd4;
    localparam cmd_t C_FIND_RD   = 5'd5;
    localparam cmd_t C_FIND_NEXT = 5'd6;
    localparam cmd_t C_GET_HIT   = 5'd7;
    localparam cmd_t C_PUT_HIT   = 5'd8;
    localparam cmd_t C_REM_HIT   = 5'd9;
    localparam cmd_t C_PB_RD     = 5'd10;
    localparam cmd_t C_PB_DEC    = 5'd11;
    localparam cmd_t C_CMP_INIT  = 5'd12;
    localparam cmd_t C_I_RD      = 5'd13;
    localparam cmd_t C_I_INC     = 5'd14;
    localparam cmd_t C_CMP_HRD   = 5'd15;
    localparam cmd_t C_CMP_WR    = 5'd16;
    localparam cmd_t C_CMP_END   = 5'd17;
    localparam cmd_t C_FULL      = 5'd18;
    localparam cmd_t C_APP_HRD   = 5'd19;
    localparam cmd_t C_APP_WR    = 5'd20;
    localparam cmd_t C_RP_RD     = 5'd21;
    localparam cmd_t C_RP_HIT    = 5'd22;
    localparam cmd_t C_SCAN_INIT = 5'd23;
    localparam cmd_t C_SCAN_CNT  = 5'd24;
    localparam cmd_t C_CLEAR     = 5'd25;
    localparam cmd_t C_OUT       = 5'd26;

    typedef struct packed {
        logic [2:0] op;
        logic       cur_none;
        logic       steps_end;
        logic       key_hit;
        logic       dead;
        logic       ap_full;
        logic       ap_zero;
        logic       pos_miss;
        logic       rp_direct;
        logic       i_end;
        logic       cnt_hit;
        logic       pull;
        logic       sweep_last;
        logic       out_free;
    } stat_t;

endpackage

### sv/ordered_chained_hash_map.sv
// Top level of the ordered chained hash map: controller plus datapath.
// Depends on ochm_pkg, ochm_controller, ochm_datapath and the defines header.
//
// One operation at a time; the result beat sits in an output register so the
// next beat is taken while it waits. Each slot and bucket memory has a single
// read port, so each operation steps through its reads and writes: get, put of
// an existing key and remove read the bucket head and then each chain entry
// visited; a remove that pulls the append point back then checks each trailing
// hole; put of a new key also reads the bucket head and appends. Read by
// position reads the slot directly when the position lies below the lowest
// hole, else scans the slots. Clear sweeps the bucket table. A put that finds
// the append point at CAPACITY first compacts: it clears the bucket table,
// then copies each live slot down over the dead ones. After reset the bucket
// table is cleared, during which no beat is accepted.
`include "ordered_chained_hash_map_defines.svh"

module ordered_chained_hash_map #(
    parameter int CAPACITY = ochm_pkg::CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_key,
    input  logic [31:0] s_value,
    input  logic [7:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_read_key,
    output logic [31:0] m_read_value,
    output logic [8:0]  m_entry_total
);

    ochm_pkg::cmd_t  cmd;
    ochm_pkg::stat_t stat;

    ochm_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ochm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_operation   (s_operation),
        .s_key         (s_key),
        .s_value       (s_value),
        .s_position    (s_position),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_read_key    (m_read_key),
        .m_read_value  (m_read_value),
        .m_entry_total (m_entry_total)
    );

    `OCHM_ASSERT_NEXT(a_one_beat_at_a_time, s_valid && s_ready, !s_ready, "input taken while busy")
    `OCHM_ASSERT_NOW(a_full_means_all_live, m_valid && (m_status == ochm_pkg::ST_FULL), m_entry_total == 9'(CAPACITY), "full reported with free slots")
    `OCHM_ASSERT_NOW(a_miss_reads_zero, m_valid && (m_status == ochm_pkg::ST_MISS), (m_read_key == '0) && (m_read_value == '0), "miss with non-zero data")

endmodule

### sv/ochm_datapath.sv
// Datapath of the ordered chained hash map: slot and bucket memories,
// pointers, counters and the result register. Depends on ochm_pkg.
module ochm_datapath #(
    parameter int CAPACITY = ochm_pkg::CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ochm_pkg::cmd_t      cmd,
    output ochm_pkg::stat_t     stat,
    input  logic [2:0]          s_operation,
    input  logic [31:0]         s_key,
    input  logic [31:0]         s_value,
    input  logic [7:0]          s_position,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [1:0]          m_status,
    output logic [31:0]         m_read_key,
    output logic [31:0]         m_read_value,
    output logic [8:0]          m_entry_total
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PTR_W = IDX_W + 1;
    localparam int CMP_W = (PTR_W > 8) ? PTR_W : 8;
    localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(CAPACITY);

    logic [31:0]      key_mem   [CAPACITY];
    logic [31:0]      value_mem [CAPACITY];
    logic [PTR_W-1:0] link_mem  [CAPACITY];
    logic             dead_mem  [CAPACITY];
    logic [PTR_W-1:0] head_mem  [CAPACITY];

    logic [2:0]       op_reg;
    logic [31:0]      key_reg;
    logic [31:0]      value_reg;
    logic [7:0]       pos_reg;
    logic [PTR_W-1:0] cur_reg;
    logic [PTR_W-1:0] prev_reg;
    logic [PTR_W-1:0] steps_reg;
    logic [PTR_W-1:0] ap_reg;
    logic [PTR_W-1:0] live_reg;
    logic [PTR_W-1:0] lh_reg;
    logic [PTR_W-1:0] i_reg;
    logic [PTR_W-1:0] j_reg;
    logic [PTR_W-1:0] cnt_reg;
    logic [IDX_W-1:0] sw_reg;
    logic [1:0]       res_status_reg;
    logic [31:0]      res_key_reg;
    logic [31:0]      res_value_reg;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [31:0]      m_read_key_reg;
    logic [31:0]      m_read_value_reg;
    logic [8:0]       m_entry_total_reg;

    logic [31:0]      key_rd_reg;
    logic [31:0]      value_rd_reg;
    logic [PTR_W-1:0] link_rd_reg;
    logic             dead_rd_reg;
    logic [PTR_W-1:0] head_rd_reg;

    logic             slot_rd_en;
    logic [IDX_W-1:0] slot_rd_addr;
    logic             head_rd_en;
    logic [IDX_W-1:0] head_rd_addr;
    logic             key_we, value_we, link_we, dead_we, head_we;
    logic [IDX_W-1:0] key_wa, value_wa, link_wa, dead_wa, head_wa;
    logic [31:0]      key_wd, value_wd;
    logic [PTR_W-1:0] link_wd, head_wd;
    logic             dead_wd;

    logic [IDX_W-1:0] key_bkt;
    logic [IDX_W-1:0] rd_bkt;
    logic [IDX_W-1:0] ap_idx;
    logic [IDX_W-1:0] j_idx;
    logic [IDX_W-1:0] cur_idx;
    logic [PTR_W-1:0] ap_dec;
    logic             pull;

    assign key_bkt = key_reg[IDX_W-1:0];
    assign rd_bkt  = key_rd_reg[IDX_W-1:0];
    assign ap_idx  = ap_reg[IDX_W-1:0];
    assign j_idx   = j_reg[IDX_W-1:0];
    assign cur_idx = cur_reg[IDX_W-1:0];
    assign ap_dec  = ap_reg - 1'b1;
    assign pull    = (PTR_W'(cur_reg + 1'b1) == ap_reg) && (live_reg > PTR_W'(1));

    always_comb begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = cur_idx;
        head_rd_en   = 1'b0;
        head_rd_addr = key_bkt;
        key_we   = 1'b0;  key_wa   = ap_idx;  key_wd   = key_reg;
        value_we = 1'b0;  value_wa = ap_idx;  value_wd = value_reg;
        link_we  = 1'b0;  link_wa  = ap_idx;  link_wd  = head_rd_reg;
        dead_we  = 1'b0;  dead_wa  = ap_idx;  dead_wd  = 1'b0;
        head_we  = 1'b0;  head_wa  = key_bkt; head_wd  = ap_reg;
        case (cmd)
            ochm_pkg::C_SWEEP: begin
                head_we = 1'b1;
                head_wa = sw_reg;
                head_wd = NO_SLOT;
            end
            ochm_pkg::C_HEAD_RD, ochm_pkg::C_APP_HRD: begin
                head_rd_en = 1'b1;
            end
            ochm_pkg::C_FIND_RD: begin
                slot_rd_en = 1'b1;
            end
            ochm_pkg::C_PUT_HIT: begin
                value_we = 1'b1;
                value_wa = cur_idx;
            end
            ochm_pkg::C_REM_HIT: begin
                // unlink from the head or from the predecessor
                if (prev_reg[IDX_W]) begin
                    head_we = 1'b1;
                    head_wd = link_rd_reg;
                end else begin
                    link_we = 1'b1;
                    link_wa = prev_reg[IDX_W-1:0];
                    link_wd = link_rd_reg;
                end
                dead_we = 1'b1;
                dead_wa = cur_idx;
                dead_wd = 1'b1;
            end
            ochm_pkg::C_PB_RD: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = ap_dec[IDX_W-1:0];
            end
            ochm_pkg::C_I_RD: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = i_reg[IDX_W-1:0];
            end
            ochm_pkg::C_CMP_HRD: begin
                head_rd_en   = 1'b1;
                head_rd_addr = rd_bkt;
            end
            ochm_pkg::C_CMP_WR: begin
                key_we   = 1'b1;  key_wa   = j_idx;  key_wd   = key_rd_reg;
                value_we = 1'b1;  value_wa = j_idx;  value_wd = value_rd_reg;
                link_we  = 1'b1;  link_wa  = j_idx;
                dead_we  = 1'b1;  dead_wa  = j_idx;
                head_we  = 1'b1;  head_wa  = rd_bkt; head_wd  = j_reg;
            end
            ochm_pkg::C_APP_WR: begin
                key_we   = 1'b1;
                value_we = 1'b1;
                link_we  = 1'b1;
                dead_we  = 1'b1;
                head_we  = 1'b1;
            end
            ochm_pkg::C_RP_RD: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = IDX_W'(pos_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[key_wa] <= key_wd;
        if (value_we) value_mem[value_wa] <= value_wd;
        if (link_we) link_mem[link_wa] <= link_wd;
        if (dead_we) dead_mem[dead_wa] <= dead_wd;
        if (head_we) head_mem[head_wa] <= head_wd;
        if (slot_rd_en) begin
            key_rd_reg   <= key_mem[slot_rd_addr];
            value_rd_reg <= value_mem[slot_rd_addr];
            link_rd_reg  <= link_mem[slot_rd_addr];
            dead_rd_reg  <= dead_mem[slot_rd_addr];
        end
        if (head_rd_en) head_rd_reg <= head_mem[head_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ap_reg      <= '0;
            live_reg    <= '0;
            lh_reg      <= NO_SLOT;
            sw_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (cmd)
                ochm_pkg::C_SWEEP: sw_reg <= sw_reg + 1'b1;
                ochm_pkg::C_REM_HIT: begin
                    if (pull) ap_reg <= ap_dec;
                    if (cur_reg < lh_reg) lh_reg <= cur_reg;
                    if (live_reg != '0) live_reg <= live_reg - 1'b1;
                end
                ochm_pkg::C_PB_DEC: ap_reg <= ap_dec;
                ochm_pkg::C_CMP_INIT: lh_reg <= NO_SLOT;
                ochm_pkg::C_CMP_END: ap_reg <= j_reg;
                ochm_pkg::C_APP_WR: begin
                    ap_reg   <= ap_reg + 1'b1;
                    live_reg <= live_reg + 1'b1;
                end
                ochm_pkg::C_CLEAR: begin
                    ap_reg   <= '0;
                    live_reg <= '0;
                    lh_reg   <= NO_SLOT;
                end
                ochm_pkg::C_OUT: m_valid_reg <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            ochm_pkg::C_LATCH: begin
                op_reg         <= s_operation;
                key_reg        <= s_key;
                value_reg      <= s_value;
                pos_reg        <= s_position;
                res_status_reg <= ochm_pkg::ST_MISS;
                res_key_reg    <= '0;
                res_value_reg  <= '0;
            end
            ochm_pkg::C_HEAD_RD: begin
                prev_reg  <= NO_SLOT;
                steps_reg <= '0;
            end
            ochm_pkg::C_CUR_LD: cur_reg <= head_rd_reg;
            ochm_pkg::C_FIND_NEXT: begin
                prev_reg  <= cur_reg;
                cur_reg   <= link_rd_reg;
                steps_reg <= steps_reg + 1'b1;
            end
            ochm_pkg::C_GET_HIT, ochm_pkg::C_PUT_HIT, ochm_pkg::C_REM_HIT: begin
                res_value_reg  <= value_rd_reg;
                res_status_reg <= ochm_pkg::ST_OK;
            end
            ochm_pkg::C_CMP_INIT: begin
                i_reg <= '0;
                j_reg <= '0;
            end
            ochm_pkg::C_I_INC: i_reg <= i_reg + 1'b1;
            ochm_pkg::C_CMP_WR: begin
                i_reg <= i_reg + 1'b1;
                j_reg <= j_reg + 1'b1;
            end
            ochm_pkg::C_FULL: res_status_reg <= ochm_pkg::ST_FULL;
            ochm_pkg::C_APP_WR, ochm_pkg::C_CLEAR: res_status_reg <= ochm_pkg::ST_OK;
            ochm_pkg::C_RP_HIT: begin
                res_key_reg    <= key_rd_reg;
                res_value_reg  <= value_rd_reg;
                res_status_reg <= ochm_pkg::ST_OK;
            end
            ochm_pkg::C_SCAN_INIT: begin
                i_reg   <= lh_reg;
                cnt_reg <= lh_reg;
            end
            ochm_pkg::C_SCAN_CNT: begin
                i_reg   <= i_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ochm_pkg::C_OUT: begin
                m_status_reg      <= res_status_reg;
                m_read_key_reg    <= res_key_reg;
                m_read_value_reg  <= res_value_reg;
                m_entry_total_reg <= 9'(live_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.op         = op_reg;
        stat.cur_none   = cur_reg[IDX_W];
        stat.steps_end  = (steps_reg == NO_SLOT);
        stat.key_hit    = (key_rd_reg == key_reg);
        stat.dead       = dead_rd_reg;
        stat.ap_full    = (ap_reg >= NO_SLOT);
        stat.ap_zero    = (ap_reg == '0);
        stat.pos_miss   = (live_reg == '0) || (CMP_W'(pos_reg) >= CMP_W'(live_reg));
        stat.rp_direct  = (live_reg == ap_reg) || (CMP_W'(pos_reg) < CMP_W'(lh_reg));
        stat.i_end      = (i_reg >= ap_reg);
        stat.cnt_hit    = (CMP_W'(cnt_reg) == CMP_W'(pos_reg));
        stat.pull       = pull;
        stat.sweep_last = (sw_reg == IDX_W'(CAPACITY - 1));
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_key    = m_read_key_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_total = m_entry_total_reg;

endmodule

### sv/ochm_controller.sv
// Sequencer of the ordered chained hash map: steps each operation through
// the datapath by command codes. Depends on ochm_pkg.
module ochm_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ochm_pkg::stat_t stat,
    output ochm_pkg::cmd_t  cmd
);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_CLD    = 5'd3;
    localparam logic [4:0] S_FRD    = 5'd4;
    localparam logic [4:0] S_FCHK   = 5'd5;
    localparam logic [4:0] S_PBRD   = 5'd6;
    localparam logic [4:0] S_PBCHK  = 5'd7;
    localparam logic [4:0] S_CMPS   = 5'd8;
    localparam logic [4:0] S_CMPSW  = 5'd9;
    localparam logic [4:0] S_CMPRD  = 5'd10;
    localparam logic [4:0] S_CMPCHK = 5'd11;
    localparam logic [4:0] S_CMPWR  = 5'd12;
    localparam logic [4:0] S_PFULL  = 5'd13;
    localparam logic [4:0] S_AHRD   = 5'd14;
    localparam logic [4:0] S_AWR    = 5'd15;
    localparam logic [4:0] S_RPHIT  = 5'd16;
    localparam logic [4:0] S_SCRD   = 5'd17;
    localparam logic [4:0] S_SCCHK  = 5'd18;
    localparam logic [4:0] S_CLRSW  = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = ochm_pkg::C_NOP;
        case (state_reg)
            S_INIT: begin
                cmd = ochm_pkg::C_SWEEP;
                if (stat.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = ochm_pkg::C_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (stat.op inside {ochm_pkg::OP_PUT, ochm_pkg::OP_GET,
                                    ochm_pkg::OP_REMOVE}) begin
                    cmd        = ochm_pkg::C_HEAD_RD;
                    state_next = S_CLD;
                end else if (stat.op == ochm_pkg::OP_READ_POS) begin
                    if (stat.pos_miss) begin
                        state_next = S_DONE;
                    end else if (stat.rp_direct) begin
                        cmd        = ochm_pkg::C_RP_RD;
                        state_next = S_RPHIT;
                    end else begin
                        cmd        = ochm_pkg::C_SCAN_INIT;
                        state_next = S_SCRD;
                    end
                end else if (stat.op == ochm_pkg::OP_CLEAR) begin
                    cmd        = ochm_pkg::C_CLEAR;
                    state_next = S_CLRSW;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CLD: begin
                cmd        = ochm_pkg::C_CUR_LD;
                state_next = S_FRD;
            end
            S_FRD: begin
                if (stat.cur_none || stat.steps_end) begin
                    // key absent: only a put goes on
                    if (stat.op != ochm_pkg::OP_PUT) begin
                        state_next = S_DONE;
                    end else if (stat.ap_full) begin
                        state_next = S_CMPS;
                    end else begin
                        state_next = S_AHRD;
                    end
                end else begin
                    cmd        = ochm_pkg::C_FIND_RD;
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                if (!stat.key_hit) begin
                    cmd        = ochm_pkg::C_FIND_NEXT;
                    state_next = S_FRD;
                end else if (stat.op == ochm_pkg::OP_GET) begin
                    cmd        = ochm_pkg::C_GET_HIT;
                    state_next = S_DONE;
                end else if (stat.op == ochm_pkg::OP_PUT) begin
                    cmd        = ochm_pkg::C_PUT_HIT;
                    state_next = S_DONE;
                end else begin
                    cmd        = ochm_pkg::C_REM_HIT;
                    state_next = stat.pull ? S_PBRD : S_DONE;
                end
            end
            S_PBRD: begin
                // pull the append point back over trailing holes
                if (stat.ap_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd        = ochm_pkg::C_PB_RD;
                    state_next = S_PBCHK;
                end
            end
            S_PBCHK: begin
                if (stat.dead) begin
                    cmd        = ochm_pkg::C_PB_DEC;
                    state_next = S_PBRD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CMPS: begin
                cmd        = ochm_pkg::C_CMP_INIT;
                state_next = S_CMPSW;
            end
            S_CMPSW: begin
                cmd = ochm_pkg::C_SWEEP;
                if (stat.sweep_last) state_next = S_CMPRD;
            end
            S_CMPRD: begin
                if (stat.i_end) begin
                    cmd        = ochm_pkg::C_CMP_END;
                    state_next = S_PFULL;
                end else begin
                    cmd        = ochm_pkg::C_I_RD;
                    state_next = S_CMPCHK;
                end
            end
            S_CMPCHK: begin
                if (stat.dead) begin
                    cmd        = ochm_pkg::C_I_INC;
                    state_next = S_CMPRD;
                end else begin
                    cmd        = ochm_pkg::C_CMP_HRD;
                    state_next = S_CMPWR;
                end
            end
            S_CMPWR: begin
                cmd        = ochm_pkg::C_CMP_WR;
                state_next = S_CMPRD;
            end
            S_PFULL: begin
                if (stat.ap_full) begin
                    cmd        = ochm_pkg::C_FULL;
                    state_next = S_DONE;
                end else begin
                    state_next = S_AHRD;
                end
            end
            S_AHRD: begin
                cmd        = ochm_pkg::C_APP_HRD;
                state_next = S_AWR;
            end
            S_AWR: begin
                cmd        = ochm_pkg::C_APP_WR;
                state_next = S_DONE;
            end
            S_RPHIT: begin
                cmd        = ochm_pkg::C_RP_HIT;
                state_next = S_DONE;
            end
            S_SCRD: begin
                if (stat.i_end) begin
                    state_next = S_DONE;
                end else begin
                    cmd        = ochm_pkg::C_I_RD;
                    state_next = S_SCCHK;
                end
            end
            S_SCCHK: begin
                if (stat.dead) begin
                    cmd        = ochm_pkg::C_I_INC;
                    state_next = S_SCRD;
                end else if (stat.cnt_hit) begin
                    cmd        = ochm_pkg::C_RP_HIT;
                    state_next = S_DONE;
                end else begin
                    cmd        = ochm_pkg::C_SCAN_CNT;
                    state_next = S_SCRD;
                end
            end
            S_CLRSW: begin
                cmd = ochm_pkg::C_SWEEP;
                if (stat.sweep_last) state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (stat.out_free) begin
                    cmd        = ochm_pkg::C_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
